@@ sv/fgn2d_pkg.sv @@
// Shared constants, codes and arithmetic helpers of the fractal gradient noise core.
// No dependencies; used by the core and by its checker.
package fgn2d_pkg;

  localparam int TABLE_SIZE  = 256;
  localparam int TBL_AW      = 8;
  localparam int MAX_OCTAVES = 8;
  localparam int OCT_W       = 3;
  localparam int FRAC_BITS   = 16;

  localparam int COORD_W    = 32;
  localparam int FREQ_W     = 24;
  localparam int PERS_W     = 16;
  localparam int PERIOD_W   = 16;
  localparam int OCTCNT_W   = 4;
  localparam int NOISE_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_OCTAVES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERSIST = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FREQ    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD  = 2'd3;

  localparam logic [OCTCNT_W-1:0] OCTAVES_RST = 4'd4;
  localparam logic [PERS_W-1:0]   PERSIST_RST = 16'd32768;
  localparam logic [FREQ_W-1:0]   FREQ_RST    = 24'd655;
  localparam logic [PERIOD_W-1:0] PERIOD_RST  = 16'd0;

  typedef struct packed {
    logic [20:0] rem;
    logic [3:0]  qbits;
  } div_step_t;

  function automatic logic signed [18:0] grad(input logic [1:0] h,
                                              input logic signed [17:0] a,
                                              input logic signed [17:0] b);
    logic signed [18:0] ae;
    logic signed [18:0] be;
    ae = 19'(a);
    be = 19'(b);
    case (h)
      2'd0:    grad = ae + be;
      2'd1:    grad = be - ae;
      2'd2:    grad = be - ae;
      default: grad = -ae - be;
    endcase
  endfunction

  function automatic logic [15:0] wrap_step(input logic [15:0] rem,
                                            input logic [3:0]  nib,
                                            input logic [15:0] per);
    logic [16:0] r;
    logic [15:0] acc;
    acc = rem;
    for (int i = 3; i >= 0; i--) begin
      r = {acc, nib[i]};
      if (r >= {1'b0, per}) begin
        r = r - {1'b0, per};
      end
      acc = r[15:0];
    end
    wrap_step = acc;
  endfunction

  function automatic div_step_t div_step(input logic [20:0] rem,
                                         input logic [3:0]  nib,
                                         input logic [20:0] d);
    logic [21:0] r;
    logic [20:0] acc;
    logic [3:0]  q;
    acc = rem;
    q   = 4'd0;
    for (int i = 3; i >= 0; i--) begin
      r = {acc, nib[i]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[i] = 1'b1;
      end
      acc = r[20:0];
    end
    div_step.rem   = acc;
    div_step.qbits = q;
  endfunction

endpackage

@@ sv/fractal_gradient_noise_2d_core.sv @@
// Fractal 2D gradient noise core: permutation table memory, octave sequencer and normaliser.
// Depends on fgn2d_pkg. Load words are taken back to back while the core is idle.
// Evaluate word: octaves run one after another, with remainder steps per octave when the
// repeat period is nonzero; the next word is taken once the core is back in idle.
// One evaluate word in flight; the last state holds while the previous result is unread.
// Synchronous active-low reset clears control and configuration; table holds junk until loaded.
module fractal_gradient_noise_2d_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_cmd,
  input  logic [7:0]           in_table_index,
  input  logic [7:0]           in_table_value,
  input  logic signed [31:0]   in_x_coord,
  input  logic signed [31:0]   in_y_coord,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [15:0]   out_noise_value,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [23:0]          cfg_wdata
);

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_MUL   = 5'd1;
  localparam logic [4:0] ST_SCALE = 5'd2;
  localparam logic [4:0] ST_WRAP  = 5'd3;
  localparam logic [4:0] ST_RD0   = 5'd4;
  localparam logic [4:0] ST_RD1   = 5'd5;
  localparam logic [4:0] ST_RD2   = 5'd6;
  localparam logic [4:0] ST_RD3   = 5'd7;
  localparam logic [4:0] ST_GRAD  = 5'd8;
  localparam logic [4:0] ST_LRP1  = 5'd9;
  localparam logic [4:0] ST_LRP2  = 5'd10;
  localparam logic [4:0] ST_LRP3  = 5'd11;
  localparam logic [4:0] ST_LRP4  = 5'd12;
  localparam logic [4:0] ST_ACC   = 5'd13;
  localparam logic [4:0] ST_NEXT  = 5'd14;
  localparam logic [4:0] ST_DIVI  = 5'd15;
  localparam logic [4:0] ST_DIV   = 5'd16;
  localparam logic [4:0] ST_OUT   = 5'd17;

  logic [4:0]  state_r, state_nxt;

  logic [3:0]  octaves_r;
  logic [15:0] persist_r;
  logic [23:0] freq_r;
  logic [15:0] period_r;

  logic [7:0]  perm_mem [fgn2d_pkg::TABLE_SIZE];
  logic [7:0]  ra, rb;
  logic [7:0]  rd_a_r, rd_b_r;
  logic        mem_we;

  logic [31:0] x_raw_r, y_raw_r;
  logic        x_neg_r, y_neg_r;
  logic [3:0]  n_r;
  logic [2:0]  oct_r;
  logic [55:0] px_r, py_r;
  logic [45:0] qx_r, qy_r;
  logic [31:0] wqx_r, wqy_r;
  logic [15:0] wrx_r, wry_r;
  logic [2:0]  wcnt_r;
  logic [7:0]  xi_r, py1_r;
  logic [15:0] fx_r, fy_r;
  logic [1:0]  ha_r, hb_r, hc_r, hd_r;
  logic signed [38:0] tax_r, tay_r;
  logic [31:0] ttx_r, tty_r, ctx_r, cty_r;
  logic signed [23:0] bx_r, by_r;
  logic signed [40:0] fpx_r, fpy_r;
  logic [16:0] u_r, v_r;
  logic signed [18:0] ga_r, gc_r;
  logic signed [19:0] d1_r, d2_r;
  logic signed [37:0] p1_r, p2_r;
  logic signed [20:0] r1_r;
  logic signed [21:0] dr_r;
  logic signed [39:0] p3_r;
  logic signed [21:0] noise_r;
  logic signed [39:0] nprod_r;
  logic [32:0] aprod_r;
  logic [16:0] amp_r;
  logic [19:0] asum_r;
  logic signed [47:0] total_r;
  logic [20:0] drem_r, dden_r;
  logic [15:0] dlow_r, dq_r;
  logic        dovf_r, dneg_r;
  logic [1:0]  dcnt_r;
  logic        out_valid_r;
  logic signed [15:0] out_noise_r;

  logic        acc_any;
  logic [3:0]  n_lim;
  logic [31:0] magx, magy;
  logic [61:0] sx, sy;
  logic [15:0] wrx_nxt, wry_nxt;
  logic [23:0] vxl, vyl;
  logic signed [21:0] ax, ay;
  logic signed [38:0] tax_nxt, tay_nxt, tarx, tary;
  logic [31:0] ttrx, ttry, ctrx, ctry;
  logic signed [40:0] fprx, fpry;
  logic signed [17:0] fx0, fx1, fy0, fy1;
  logic signed [18:0] ga, gb, gc, gd;
  logic signed [37:0] p1rn, p2rn;
  logic signed [20:0] r1, r2;
  logic signed [39:0] p3rn;
  logic [32:0] aprn;
  logic [47:0] tmag;
  logic [48:0] dnum;
  logic [20:0] dden;
  fgn2d_pkg::div_step_t dstep;
  logic signed [15:0] result;

  assign in_ready        = (state_r == ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_noise_value = out_noise_r;
  assign acc_any         = in_valid && in_ready;
  assign mem_we          = acc_any && (in_cmd == fgn2d_pkg::CMD_LOAD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      octaves_r <= fgn2d_pkg::OCTAVES_RST;
      persist_r <= fgn2d_pkg::PERSIST_RST;
      freq_r    <= fgn2d_pkg::FREQ_RST;
      period_r  <= fgn2d_pkg::PERIOD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        fgn2d_pkg::REG_OCTAVES: octaves_r <= cfg_wdata[3:0];
        fgn2d_pkg::REG_PERSIST: persist_r <= cfg_wdata[15:0];
        fgn2d_pkg::REG_FREQ:    freq_r    <= cfg_wdata;
        fgn2d_pkg::REG_PERIOD:  period_r  <= cfg_wdata[15:0];
        default:                octaves_r <= octaves_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      perm_mem[in_table_index] <= in_table_value;
    end
    rd_a_r <= perm_mem[ra];
    rd_b_r <= perm_mem[rb];
  end

  always_comb begin
    n_lim = octaves_r;
    if (octaves_r == 4'd0) begin
      n_lim = 4'd1;
    end else if (octaves_r > 4'(fgn2d_pkg::MAX_OCTAVES)) begin
      n_lim = 4'(fgn2d_pkg::MAX_OCTAVES);
    end

    magx = x_neg_r ? (~x_raw_r + 32'd1) : x_raw_r;
    magy = y_neg_r ? (~y_raw_r + 32'd1) : y_raw_r;
    sx = ({6'd0, px_r} << oct_r) + (x_neg_r ? 62'h0FFFF : 62'd0);
    sy = ({6'd0, py_r} << oct_r) + (y_neg_r ? 62'h0FFFF : 62'd0);

    wrx_nxt = fgn2d_pkg::wrap_step(wrx_r, wqx_r[31:28], period_r);
    wry_nxt = fgn2d_pkg::wrap_step(wry_r, wqy_r[31:28], period_r);

    vxl = x_neg_r ? (24'd0 - qx_r[23:0]) : qx_r[23:0];
    vyl = y_neg_r ? (24'd0 - qy_r[23:0]) : qy_r[23:0];

    ax = 22'sd6 * $signed({6'd0, fx_r}) - 22'sd983040;
    ay = 22'sd6 * $signed({6'd0, fy_r}) - 22'sd983040;
    tax_nxt = 39'(ax) * 39'($signed({1'b0, fx_r}));
    tay_nxt = 39'(ay) * 39'($signed({1'b0, fy_r}));
    tarx = (tax_r + 39'sd32768) >>> 16;
    tary = (tay_r + 39'sd32768) >>> 16;
    ttrx = ttx_r + 32'd32768;
    ttry = tty_r + 32'd32768;
    ctrx = ctx_r + 32'd32768;
    ctry = cty_r + 32'd32768;
    fprx = (fpx_r + 41'sd32768) >>> 16;
    fpry = (fpy_r + 41'sd32768) >>> 16;

    fx0 = $signed({2'b00, fx_r});
    fx1 = fx0 - 18'sd65536;
    fy0 = $signed({2'b00, fy_r});
    fy1 = fy0 - 18'sd65536;
    ga = fgn2d_pkg::grad(ha_r, fx0, fy0);
    gb = fgn2d_pkg::grad(hb_r, fx1, fy0);
    gc = fgn2d_pkg::grad(hc_r, fx0, fy1);
    gd = fgn2d_pkg::grad(hd_r, fx1, fy1);

    p1rn = (p1_r + 38'sd32768) >>> 16;
    p2rn = (p2_r + 38'sd32768) >>> 16;
    r1 = 21'(ga_r) + p1rn[20:0];
    r2 = 21'(gc_r) + p2rn[20:0];
    p3rn = (p3_r + 40'sd32768) >>> 16;
    aprn = aprod_r + 33'd32768;

    tmag  = total_r[47] ? (48'd0 - total_r) : total_r;
    dnum  = {1'b0, tmag} + {29'd0, asum_r};
    dden  = {asum_r, 1'b0};
    dstep = fgn2d_pkg::div_step(drem_r, dlow_r[15:12], dden_r);

    if (dneg_r) begin
      result = (dovf_r || dq_r[15]) ? 16'sh8000 : $signed(16'd0 - dq_r);
    end else begin
      result = (dovf_r || dq_r[15]) ? 16'sh7FFF : $signed(dq_r);
    end
  end

  always_comb begin
    ra = vyl[23:16];
    rb = vyl[23:16] + 8'd1;
    case (state_r)
      ST_RD1: begin
        ra = xi_r + rd_a_r;
        rb = xi_r + 8'd1 + rd_a_r;
      end
      ST_RD2: begin
        ra = xi_r + py1_r;
        rb = xi_r + 8'd1 + py1_r;
      end
      default: begin
        ra = vyl[23:16];
        rb = vyl[23:16] + 8'd1;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  state_nxt = (acc_any && in_cmd == fgn2d_pkg::CMD_EVAL) ? ST_MUL : ST_IDLE;
      ST_MUL:   state_nxt = ST_SCALE;
      ST_SCALE: state_nxt = (period_r != 16'd0) ? ST_WRAP : ST_RD0;
      ST_WRAP:  state_nxt = (wcnt_r == 3'd7) ? ST_RD0 : ST_WRAP;
      ST_RD0:   state_nxt = ST_RD1;
      ST_RD1:   state_nxt = ST_RD2;
      ST_RD2:   state_nxt = ST_RD3;
      ST_RD3:   state_nxt = ST_GRAD;
      ST_GRAD:  state_nxt = ST_LRP1;
      ST_LRP1:  state_nxt = ST_LRP2;
      ST_LRP2:  state_nxt = ST_LRP3;
      ST_LRP3:  state_nxt = ST_LRP4;
      ST_LRP4:  state_nxt = ST_ACC;
      ST_ACC:   state_nxt = ST_NEXT;
      ST_NEXT:  state_nxt = ({1'b0, oct_r} == n_r - 4'd1) ? ST_DIVI : ST_MUL;
      ST_DIVI:  state_nxt = ST_DIV;
      ST_DIV:   state_nxt = (dcnt_r == 2'd3) ? ST_OUT : ST_DIV;
      ST_OUT:   state_nxt = (!out_valid_r || out_ready) ? ST_IDLE : ST_OUT;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_OUT && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        x_raw_r <= in_x_coord;
        y_raw_r <= in_y_coord;
        x_neg_r <= in_x_coord[31];
        y_neg_r <= in_y_coord[31];
        n_r     <= n_lim;
        oct_r   <= 3'd0;
        total_r <= 48'sd0;
        amp_r   <= 17'd65536;
        asum_r  <= 20'd0;
      end
      ST_MUL: begin
        px_r <= 56'(magx) * 56'(freq_r);
        py_r <= 56'(magy) * 56'(freq_r);
      end
      ST_SCALE: begin
        qx_r   <= sx[61:16];
        qy_r   <= sy[61:16];
        wqx_r  <= {2'b00, sx[61:32]};
        wqy_r  <= {2'b00, sy[61:32]};
        wrx_r  <= 16'd0;
        wry_r  <= 16'd0;
        wcnt_r <= 3'd0;
      end
      ST_WRAP: begin
        wrx_r  <= wrx_nxt;
        wry_r  <= wry_nxt;
        wqx_r  <= {wqx_r[27:0], 4'd0};
        wqy_r  <= {wqy_r[27:0], 4'd0};
        wcnt_r <= wcnt_r + 3'd1;
        if (wcnt_r == 3'd7) begin
          qx_r <= {14'd0, wrx_nxt, qx_r[15:0]};
          qy_r <= {14'd0, wry_nxt, qy_r[15:0]};
        end
      end
      ST_RD0: begin
        xi_r <= vxl[23:16];
        fx_r <= vxl[15:0];
        fy_r <= vyl[15:0];
      end
      ST_RD1: begin
        py1_r <= rd_b_r;
        tax_r <= tax_nxt;
        tay_r <= tay_nxt;
        ttx_r <= 32'(fx_r) * 32'(fx_r);
        tty_r <= 32'(fy_r) * 32'(fy_r);
      end
      ST_RD2: begin
        ha_r  <= rd_a_r[1:0];
        hb_r  <= rd_b_r[1:0];
        bx_r  <= $signed(tarx[23:0]) + 24'sd655360;
        by_r  <= $signed(tary[23:0]) + 24'sd655360;
        ctx_r <= 32'(ttrx[31:16]) * 32'(fx_r);
        cty_r <= 32'(ttry[31:16]) * 32'(fy_r);
      end
      ST_RD3: begin
        hc_r  <= rd_a_r[1:0];
        hd_r  <= rd_b_r[1:0];
        fpx_r <= 41'($signed({1'b0, ctrx[31:16]})) * 41'(bx_r);
        fpy_r <= 41'($signed({1'b0, ctry[31:16]})) * 41'(by_r);
      end
      ST_GRAD: begin
        u_r  <= fprx[40] ? 17'd0 : ((fprx > 41'sd65536) ? 17'd65536 : fprx[16:0]);
        v_r  <= fpry[40] ? 17'd0 : ((fpry > 41'sd65536) ? 17'd65536 : fpry[16:0]);
        ga_r <= ga;
        gc_r <= gc;
        d1_r <= 20'(gb) - 20'(ga);
        d2_r <= 20'(gd) - 20'(gc);
      end
      ST_LRP1: begin
        p1_r <= 38'($signed({1'b0, u_r})) * 38'(d1_r);
        p2_r <= 38'($signed({1'b0, u_r})) * 38'(d2_r);
      end
      ST_LRP2: begin
        r1_r <= r1;
        dr_r <= 22'(r2) - 22'(r1);
      end
      ST_LRP3: begin
        p3_r <= 40'($signed({1'b0, v_r})) * 40'(dr_r);
      end
      ST_LRP4: begin
        noise_r <= 22'(r1_r) + p3rn[21:0];
      end
      ST_ACC: begin
        nprod_r <= 40'(noise_r) * 40'($signed({1'b0, amp_r}));
        aprod_r <= 33'(amp_r) * 33'(persist_r);
      end
      ST_NEXT: begin
        total_r <= total_r + 48'(nprod_r);
        asum_r  <= asum_r + 20'(amp_r);
        amp_r   <= aprn[32:16];
        oct_r   <= oct_r + 3'd1;
      end
      ST_DIVI: begin
        dneg_r <= total_r[47];
        dovf_r <= dnum >= {12'd0, dden, 16'd0};
        drem_r <= dnum[36:16];
        dlow_r <= dnum[15:0];
        dden_r <= dden;
        dq_r   <= 16'd0;
        dcnt_r <= 2'd0;
      end
      ST_DIV: begin
        drem_r <= dstep.rem;
        dq_r   <= {dq_r[11:0], dstep.qbits};
        dlow_r <= {dlow_r[11:0], 4'd0};
        dcnt_r <= dcnt_r + 2'd1;
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_noise_r <= result;
        end
      end
      default: begin
        oct_r <= oct_r;
      end
    endcase
  end

endmodule

@@ sv/fgn2d_checker.sv @@
// Port-level checker for the fractal gradient noise core, bound into the core module.
// Depends on fgn2d_pkg and fractal_gradient_noise_2d_core.
module fgn2d_port_checks (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              in_cmd,
  input logic              out_valid,
  input logic              out_ready,
  input logic signed [15:0] out_noise_value
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_noise_value))
    else $error("result word dropped or changed while stalled");

  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && in_valid && in_ready && in_cmd == fgn2d_pkg::CMD_LOAD |=> !out_valid)
    else $error("table load produced a result word");

  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_cmd == fgn2d_pkg::CMD_EVAL |=> !in_ready)
    else $error("input taken while a point is in progress");

  a_rise_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result word appeared without a point in progress");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind fractal_gradient_noise_2d_core fgn2d_port_checks u_fgn2d_port_checks (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_cmd          (in_cmd),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_noise_value (out_noise_value)
);

@@ tb/fgn2d_checker.sv @@
// Checker for the fractal gradient noise core: watches the word and result channels,
// predicts every noise value from its own table and register copies, and compares.
// Depends on fgn2d_pkg.
`timescale 1ns / 100ps

module fgn2d_checker (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  input  logic                                  in_ready,
  input  logic                                  in_cmd,
  input  logic [7:0]                            in_table_index,
  input  logic [7:0]                            in_table_value,
  input  logic signed [fgn2d_pkg::COORD_W-1:0]  in_x_coord,
  input  logic signed [fgn2d_pkg::COORD_W-1:0]  in_y_coord,
  input  logic                                  out_valid,
  input  logic                                  out_ready,
  input  logic signed [fgn2d_pkg::NOISE_W-1:0]  out_noise_value,
  input  logic                                  cfg_we,
  input  logic [fgn2d_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fgn2d_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  output int                                    errors,
  output int                                    pending
);

  localparam longint ONE_FX = longint'(1) << fgn2d_pkg::FRAC_BITS;

  logic [7:0]                     perm_copy [fgn2d_pkg::TABLE_SIZE];
  logic [fgn2d_pkg::OCTCNT_W-1:0] octaves;
  logic [fgn2d_pkg::PERS_W-1:0]   persist;
  logic [fgn2d_pkg::FREQ_W-1:0]   freq;
  logic [fgn2d_pkg::PERIOD_W-1:0] period;
  logic signed [fgn2d_pkg::NOISE_W-1:0] noise_fifo [$];

  function automatic longint round_fx(longint v);
    longint w;
    w = v + (ONE_FX >>> 1);
    if (w >= 0) return w >>> fgn2d_pkg::FRAC_BITS;
    return -((-w + ONE_FX - 1) >>> fgn2d_pkg::FRAC_BITS);
  endfunction

  function automatic longint floor_int(longint v);
    if (v >= 0) return v >>> fgn2d_pkg::FRAC_BITS;
    return -((-v + ONE_FX - 1) >>> fgn2d_pkg::FRAC_BITS);
  endfunction

  function automatic longint perm_at(longint idx);
    longint k;
    k = ((idx % fgn2d_pkg::TABLE_SIZE) + fgn2d_pkg::TABLE_SIZE) % fgn2d_pkg::TABLE_SIZE;
    return longint'(perm_copy[k]);
  endfunction

  function automatic longint fade(longint t);
    longint a, b, c, f;
    a = 6 * t - 15 * ONE_FX;
    b = round_fx(t * a) + 10 * ONE_FX;
    c = round_fx(t * t);
    c = round_fx(c * t);
    f = round_fx(c * b);
    if (f < 0) f = 0;
    if (f > ONE_FX) f = ONE_FX;
    return f;
  endfunction

  function automatic longint corner(longint h, longint a, longint b);
    longint u, v;
    u = (h[1] == 1'b0) ? a : b;
    v = (h[1] == 1'b0) ? b : a;
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  function automatic longint blend(longint a, longint b, longint t);
    return a + round_fx(t * (b - a));
  endfunction

  function automatic longint scaled(logic [31:0] raw, int oct);
    logic [63:0] mag, p, q;
    int sh;
    mag = raw[31] ? (64'h1_0000_0000 - {32'd0, raw}) : {32'd0, raw};
    p   = mag * {40'd0, freq};
    sh  = fgn2d_pkg::FRAC_BITS - oct;
    q   = raw[31] ? ((p + ((64'd1 << sh) - 64'd1)) >> sh) : (p >> sh);
    return raw[31] ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint octave_noise(longint vx, longint vy);
    longint ix, iy, fx, fy, xi, yi, py0, py1, aa, ba, ab, bb, u, v, r1, r2;
    ix  = floor_int(vx);
    iy  = floor_int(vy);
    fx  = vx - ix * ONE_FX;
    fy  = vy - iy * ONE_FX;
    xi  = ((ix % fgn2d_pkg::TABLE_SIZE) + fgn2d_pkg::TABLE_SIZE) % fgn2d_pkg::TABLE_SIZE;
    yi  = ((iy % fgn2d_pkg::TABLE_SIZE) + fgn2d_pkg::TABLE_SIZE) % fgn2d_pkg::TABLE_SIZE;
    py0 = perm_at(yi);
    py1 = perm_at(yi + 1);
    aa  = perm_at(xi + py0);
    ba  = perm_at(xi + 1 + py0);
    ab  = perm_at(xi + py1);
    bb  = perm_at(xi + 1 + py1);
    u   = fade(fx);
    v   = fade(fy);
    r1  = blend(corner(aa, fx, fy), corner(ba, fx - ONE_FX, fy), u);
    r2  = blend(corner(ab, fx, fy - ONE_FX), corner(bb, fx - ONE_FX, fy - ONE_FX), u);
    return blend(r1, r2, v);
  endfunction

  function automatic logic signed [fgn2d_pkg::NOISE_W-1:0] fractal_noise(logic [31:0] xr,
                                                                         logic [31:0] yr);
    int n;
    longint total, vx, vy, m, res;
    logic [63:0] amp, amp_sum, mag, den, q;
    total   = 0;
    amp     = 64'd65536;
    amp_sum = 64'd0;
    n = int'(octaves);
    if (n < 1) n = 1;
    if (n > fgn2d_pkg::MAX_OCTAVES) n = fgn2d_pkg::MAX_OCTAVES;
    for (int i = 0; i < n; i++) begin
      vx = scaled(xr, i);
      vy = scaled(yr, i);
      if (period != 0) begin
        m  = longint'(period) * ONE_FX;
        vx = vx % m;
        vy = vy % m;
      end
      total   = total + octave_noise(vx, vy) * longint'(amp);
      amp_sum = amp_sum + amp;
      amp     = (amp * {48'd0, persist} + 64'd32768) >> 16;
    end
    mag = (total < 0) ? 64'(-total) : 64'(total);
    den = amp_sum << fgn2d_pkg::FRAC_BITS;
    q   = ((mag << 15) + (den >> 1)) / den;
    if (q > 64'd65536) q = 64'd65536;
    res = (total < 0) ? -longint'(q) : longint'(q);
    if (res > 32767) res = 32767;
    if (res < -32768) res = -32768;
    return res[fgn2d_pkg::NOISE_W-1:0];
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    errors++;
  endtask

  initial begin
    errors  = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    logic signed [fgn2d_pkg::NOISE_W-1:0] want;
    if (!rst_n) begin
      octaves <= fgn2d_pkg::OCTAVES_RST;
      persist <= fgn2d_pkg::PERSIST_RST;
      freq    <= fgn2d_pkg::FREQ_RST;
      period  <= fgn2d_pkg::PERIOD_RST;
      noise_fifo.delete();
      pending <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          fgn2d_pkg::REG_OCTAVES: octaves <= cfg_wdata[fgn2d_pkg::OCTCNT_W-1:0];
          fgn2d_pkg::REG_PERSIST: persist <= cfg_wdata[fgn2d_pkg::PERS_W-1:0];
          fgn2d_pkg::REG_FREQ:    freq    <= cfg_wdata[fgn2d_pkg::FREQ_W-1:0];
          fgn2d_pkg::REG_PERIOD:  period  <= cfg_wdata[fgn2d_pkg::PERIOD_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (in_cmd == fgn2d_pkg::CMD_LOAD) begin
          perm_copy[in_table_index] = in_table_value;
        end else begin
          noise_fifo.insert(noise_fifo.size(), fractal_noise(in_x_coord, in_y_coord));
        end
      end
      if (out_valid && out_ready) begin
        if (noise_fifo.size() == 0) begin
          report_mismatch($sformatf("unexpected noise %0d", out_noise_value));
        end else begin
          want = noise_fifo.pop_front();
          if (out_noise_value !== want)
            report_mismatch($sformatf("noise %0d, predicted %0d", out_noise_value, want));
        end
      end
      pending <= noise_fifo.size();
    end
  end

endmodule

@@ tb/tb.sv @@
// Top of the fractal gradient noise testbench: clock, reset, word and register stimulus,
// result back-pressure and the verdict. Depends on fgn2d_pkg, fgn2d_checker and the core.
`timescale 1ns / 100ps

module tb;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN       = 200;

  logic                                 clk;
  logic                                 rst_n;
  logic                                 in_valid;
  logic                                 in_ready;
  logic                                 in_cmd;
  logic [7:0]                           in_table_index;
  logic [7:0]                           in_table_value;
  logic signed [fgn2d_pkg::COORD_W-1:0] in_x_coord;
  logic signed [fgn2d_pkg::COORD_W-1:0] in_y_coord;
  logic                                 out_valid;
  logic                                 out_ready;
  logic signed [fgn2d_pkg::NOISE_W-1:0] out_noise_value;
  logic                                 cfg_we;
  logic [fgn2d_pkg::CFG_IDX_W-1:0]      cfg_index;
  logic [fgn2d_pkg::CFG_DATA_W-1:0]     cfg_wdata;
  int                                   errors;
  int                                   pending;
  int                                   cycles;
  int                                   burst_left;
  int                                   stall_pct;
  logic                                 hold_off;
  logic                                 hold_go;

  fractal_gradient_noise_2d_core u_dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_cmd, .in_table_index, .in_table_value,
    .in_x_coord, .in_y_coord, .out_valid, .out_ready, .out_noise_value,
    .cfg_we, .cfg_index, .cfg_wdata
  );

  fgn2d_checker u_chk (
    .clk, .rst_n, .in_valid, .in_ready, .in_cmd, .in_table_index, .in_table_value,
    .in_x_coord, .in_y_coord, .out_valid, .out_ready, .out_noise_value,
    .cfg_we, .cfg_index, .cfg_wdata, .errors, .pending
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (cycles % 150 == 0) stall_pct = $urandom_range(0, 3) * 25;
    out_ready = !hold_off && ($urandom_range(0, 99) >= stall_pct);
  end

  initial begin
    wait (hold_go);
    hold_off = 1'b1;
    repeat (800) @(negedge clk);
    hold_off = 1'b0;
  end

  task automatic send_word(logic cmd, logic [7:0] idx, logic [7:0] val,
                           logic [31:0] x, logic [31:0] y);
    in_valid       = 1'b1;
    in_cmd         = cmd;
    in_table_index = idx;
    in_table_value = val;
    in_x_coord     = x;
    in_y_coord     = y;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // pause between bursts
  task automatic pace();
    if (burst_left <= 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = $urandom_range(1, 25);
    end
    burst_left--;
  endtask

  task automatic settle();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  task automatic write_reg(logic [fgn2d_pkg::CFG_IDX_W-1:0] idx,
                           logic [fgn2d_pkg::CFG_DATA_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic eval_point(logic [31:0] x, logic [31:0] y);
    pace();
    send_word(fgn2d_pkg::CMD_EVAL, 8'($urandom), 8'($urandom), x, y);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return 32'($signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000);
      2:       return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
      default: return 32'($signed($urandom_range(0, 32'h3FFF_FFFF)) - 32'sh2000_0000);
    endcase
  endfunction

  task automatic random_words(int count);
    for (int i = 0; i < count; i++) begin
      pace();
      if ($urandom_range(0, 99) < 15)
        send_word(fgn2d_pkg::CMD_LOAD, 8'($urandom), 8'($urandom), $urandom, $urandom);
      else
        send_word(fgn2d_pkg::CMD_EVAL, 8'($urandom), 8'($urandom), rand_coord(),
                  rand_coord());
    end
  endtask

  initial begin
    cycles         = 0;
    stall_pct      = 0;
    burst_left     = 0;
    hold_off       = 1'b0;
    hold_go        = 1'b0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_cmd         = fgn2d_pkg::CMD_LOAD;
    in_table_index = '0;
    in_table_value = '0;
    in_x_coord     = '0;
    in_y_coord     = '0;
    out_ready      = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = fgn2d_pkg::REG_OCTAVES;
    cfg_wdata      = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // fill the whole table before any evaluation
    for (int i = 0; i < fgn2d_pkg::TABLE_SIZE; i++) begin
      pace();
      send_word(fgn2d_pkg::CMD_LOAD, 8'(i), 8'($urandom), $urandom, $urandom);
    end

    eval_point(32'h0000_0000, 32'h0000_0000);
    eval_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    eval_point(32'h8000_0000, 32'h8000_0000);
    eval_point(32'h7FFF_FFFF, 32'h8000_0000);
    eval_point(32'hFFFF_FFFF, 32'h0000_0001);
    eval_point(32'h0000_8000, 32'hFFFF_8000);
    eval_point(32'h0001_0000, 32'hFFFF_0000);
    settle();

    write_reg(fgn2d_pkg::REG_OCTAVES, 24'd1);
    write_reg(fgn2d_pkg::REG_PERSIST, 24'd0);
    write_reg(fgn2d_pkg::REG_FREQ,    24'hFF_FFFF);
    write_reg(fgn2d_pkg::REG_PERIOD,  24'd0);
    eval_point(32'h7FFF_FFFF, 32'h8000_0000);
    eval_point(32'h0000_0001, 32'hFFFF_FFFF);
    eval_point(32'h1234_5678, 32'h8765_4321);
    settle();

    write_reg(fgn2d_pkg::REG_OCTAVES, 24'd8);
    write_reg(fgn2d_pkg::REG_PERSIST, 24'hFFFF);
    write_reg(fgn2d_pkg::REG_FREQ,    24'h01_0000);
    write_reg(fgn2d_pkg::REG_PERIOD,  24'd1);
    eval_point(32'h8000_0000, 32'h7FFF_FFFF);
    eval_point(32'h0003_4000, 32'hFFFC_C000);
    settle();

    write_reg(fgn2d_pkg::REG_OCTAVES, 24'd0);
    write_reg(fgn2d_pkg::REG_PERIOD,  24'hFFFF);
    write_reg(fgn2d_pkg::REG_FREQ,    24'd0);
    eval_point(32'h7FFF_FFFF, 32'h8000_0000);
    settle();
    write_reg(fgn2d_pkg::REG_FREQ,    24'h00_0100);
    eval_point(32'h8000_0000, 32'h7FFF_FFFF);
    settle();

    write_reg(fgn2d_pkg::REG_OCTAVES, 24'd15);
    write_reg(fgn2d_pkg::REG_PERIOD,  24'd7);
    write_reg(fgn2d_pkg::REG_FREQ,    24'h00_8000);
    eval_point(32'hFFF9_0000, 32'h0007_0000);
    random_words(120);
    settle();

    for (int phase = 0; phase < 6; phase++) begin
      write_reg(fgn2d_pkg::REG_OCTAVES, 24'($urandom_range(0, 15)));
      write_reg(fgn2d_pkg::REG_PERSIST, 24'($urandom_range(0, 65535)));
      write_reg(fgn2d_pkg::REG_FREQ,    ($urandom_range(0, 1)) ? 24'($urandom) :
                                        24'($urandom_range(0, 24'h04_0000)));
      write_reg(fgn2d_pkg::REG_PERIOD,  ($urandom_range(0, 2) == 0) ? 24'd0 :
                                        24'($urandom_range(1, 65535)));
      if (phase == 2) hold_go = 1'b1;
      random_words(95);
      settle();
    end

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
